// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helper macros, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property checked only outside reset
`define EGAS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`else
`define EGAS_ASSERT(lbl, clk, rst, prop)
`endif

`ifndef SYNTHESIS
// property checked at every edge, reset included
`define EGAS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define EGAS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- src/egas_pkg.sv -----
// ----------------------------------------------------------------------------
// egas_pkg
// shared types and constants of the epsilon-greedy arm selector
// ----------------------------------------------------------------------------
`default_nettype none

package egas_pkg;

  // register indexes on the config port
  localparam logic [1:0] REG_EPS_INIT    = 2'd0;
  localparam logic [1:0] REG_EPS_RESTART = 2'd1;
  localparam logic [1:0] REG_DECAY       = 2'd2;

  // register reset values, q0.16
  localparam logic [15:0] EPS_INIT_RST    = 16'd29491;
  localparam logic [15:0] EPS_RESTART_RST = 16'd26214;
  localparam logic [15:0] DECAY_RST       = 16'd64251;

  localparam logic [16:0] Q16_ONE   = 17'h10000;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  localparam int ARM_W  = 6;
  localparam int DIV_QW = 17;
  localparam int DIV_RW = 32;

  localparam logic [4:0] RATIO_STEPS = 5'd16;
  localparam logic [4:0] FULL_STEPS  = 5'd17;
  localparam logic [4:0] MUL_STEPS   = 5'd16;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_RSTART,
    S_RDIV,
    S_VSTART,
    S_VDIV,
    S_WR,
    S_EXPL,
    S_WALK,
    S_WEND,
    S_PICK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [4:0]        steps;
    logic [DIV_RW-1:0] init_rem;
    logic [DIV_QW-1:0] dividend;
    logic [DIV_RW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic        start;
    logic [15:0] a;
    logic [15:0] b;
  } mul_req_t;

endpackage

`default_nettype wire

// ----- src/egas_divider.sv -----
// ----------------------------------------------------------------------------
// egas_divider
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module egas_divider import egas_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  div_req_t          req,
  output div_stat_t         stat,
  output logic [DIV_QW-1:0] quo,
  output logic [DIV_RW-1:0] rem
);

  logic [DIV_QW-1:0] dvd;
  logic [DIV_RW-1:0] dsr;
  logic [4:0]        cnt;
  logic              busy;
  logic              done;
  logic [DIV_RW:0]   trial;
  logic [DIV_RW:0]   diff;
  logic              take;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem, dvd[DIV_QW-1]};
  assign diff  = trial - {1'b0, dsr};
  assign take  = ~diff[DIV_RW];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.init_rem;
      dvd <= req.dividend;
      dsr <= req.divisor;
      quo <= '0;
    end else if (busy) begin
      rem <= take ? diff[DIV_RW-1:0] : trial[DIV_RW-1:0];
      dvd <= {dvd[DIV_QW-2:0], 1'b0};
      quo <= {quo[DIV_QW-2:0], take};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

  `EGAS_ASSERT(a_div_no_restart, clk, rst, req.start |-> !busy)
  `EGAS_ASSERT(a_div_runs_to_done, clk, rst, busy |=> (busy || done))
  `EGAS_ASSERT_ALWAYS(a_div_done_idle, clk, !(busy && done))
  `EGAS_ASSERT(a_div_rem_below, clk, rst, (busy || done) |-> (rem < dsr))

endmodule

`default_nettype wire

// ----- src/egas_multiplier.sv -----
// ----------------------------------------------------------------------------
// egas_multiplier
// bit-serial shift-add multiplier giving floor(a * b / 2^16)
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module egas_multiplier import egas_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  mul_req_t    req,
  output logic        busy,
  output logic [15:0] prod
);

  logic [15:0] a;
  logic [15:0] b;
  logic [4:0]  cnt;
  logic [16:0] sum;

  // lsb-first over b, low product bits drop out one per step
  assign sum = {1'b0, prod} + (b[0] ? {1'b0, a} : 17'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= MUL_STEPS;
    end else if (busy) begin
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a    <= req.a;
      b    <= req.b;
      prod <= '0;
    end else if (busy) begin
      b    <= {1'b0, b[15:1]};
      prod <= sum[16:1];
    end
  end

  `EGAS_ASSERT(a_mul_no_restart, clk, rst, req.start |-> !busy)
  `EGAS_ASSERT(a_mul_ends, clk, rst, (busy && cnt == 5'd1 && !req.start) |=> !busy)
  `EGAS_ASSERT(a_mul_holds, clk, rst, (!busy && !req.start) |=> $stable(prod))

endmodule

`default_nettype wire

// ----- src/epsilon_greedy_arm_selector_core.sv -----
// ----------------------------------------------------------------------------
// epsilon_greedy_arm_selector_core
// epsilon-greedy bandit: value update, exploration and greedy arm choice
// ----------------------------------------------------------------------------
// One item is worked at a time. A round item runs a 16-step serial
// division for the delivery ratio (skipped when the total is zero or the
// successes reach the total), a 17-step serial division of the value
// difference by the pull count, then either a 17-step serial modulo of
// random_arm with the epsilon decay multiply running beside it, or a walk
// over the arm memory reading one arm per cycle for the greedy pick. The
// bit-serial divider is shared by all three divisions. A finished result
// sits in the output register, so the next item is taken while it waits.
// Arm values and pull counts live in a memory with one valid bit per arm;
// a reset item clears all the valid bits at once, so no clearing pass is
// needed.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module epsilon_greedy_arm_selector_core import egas_pkg::*; #(
  parameter int NUM_ARMS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // success_count, total_count, random_fraction, random_arm
  input  logic [63:0] s_axis_tdata,
  // func
  input  logic [0:0]  s_axis_tuser,
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // chosen_arm, delivery_ratio, updated_value, epsilon_now
  output logic [55:0] m_axis_tdata,
  // explored
  output logic [0:0]  m_axis_tuser,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = (NUM_ARMS > 1) ? $clog2(NUM_ARMS) : 1;
  localparam int CW = AW + 1;

  state_t state, state_next;

  // config registers
  logic [15:0] eps_init;
  logic [15:0] eps_restart;
  logic [15:0] decay;
  logic        cfg_we;

  // working state
  logic [15:0]   eps_value;
  logic [AW-1:0] cur_arm;
  logic [15:0]   succ_q;
  logic [15:0]   tot_q;
  logic [15:0]   rfrac_q;
  logic [15:0]   rarm_q;
  logic [16:0]   ratio;
  logic [31:0]   cnt_new;
  logic          diff_neg;
  logic [16:0]   new_val;
  logic          explore;
  logic [AW-1:0] next_arm;

  // arm memory, one valid bit per arm
  logic [16:0]         val_mem [NUM_ARMS];
  logic [31:0]         cnt_mem [NUM_ARMS];
  logic [NUM_ARMS-1:0] arm_valid;
  logic                mem_rd;
  logic                mem_we;
  logic [AW-1:0]       mem_addr;
  logic [16:0]         rd_val;
  logic [31:0]         rd_cnt;
  logic                rd_valid;
  logic [AW-1:0]       rd_tag;
  logic                rd_live;
  logic [16:0]         eff_val;
  logic [31:0]         eff_cnt;

  // greedy walk
  logic [CW-1:0] walk_idx;
  logic [AW-1:0] best_idx;
  logic [16:0]   best_val;

  // arithmetic helpers
  logic [17:0] diff_full;
  logic [16:0] diff_mag;
  logic [31:0] cnt_inc;
  logic        explore_c;
  logic        ratio_skip;
  logic        s_acc;
  logic        out_free;

  // serial units
  div_req_t          div_req;
  div_stat_t         div_stat;
  logic [DIV_QW-1:0] div_quo;
  logic [DIV_RW-1:0] div_rem;
  mul_req_t          mul_req;
  logic              mul_busy;
  logic [15:0]       mul_prod;

  egas_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .stat (div_stat),
    .quo  (div_quo),
    .rem  (div_rem)
  );

  egas_multiplier u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req),
    .busy (mul_busy),
    .prod (mul_prod)
  );

  // -------------------------------------------------------------------------
  // config port, always ready, decode on the word address
  // -------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps_init    <= EPS_INIT_RST;
      eps_restart <= EPS_RESTART_RST;
      decay       <= DECAY_RST;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_EPS_INIT:    eps_init    <= pwdata[15:0];
        REG_EPS_RESTART: eps_restart <= pwdata[15:0];
        REG_DECAY:       decay       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_EPS_INIT:    prdata = {16'd0, eps_init};
      REG_EPS_RESTART: prdata = {16'd0, eps_restart};
      REG_DECAY:       prdata = {16'd0, decay};
      default:         prdata = 32'd0;
    endcase
  end

  // -------------------------------------------------------------------------
  // helpers
  // -------------------------------------------------------------------------
  assign s_acc    = s_axis_tvalid & s_axis_tready;
  assign out_free = ~m_axis_tvalid | m_axis_tready;

  // never-written arms read as zero
  assign eff_val = rd_valid ? rd_val : 17'd0;
  assign eff_cnt = rd_valid ? rd_cnt : 32'd0;

  // pull count saturates at all ones
  assign cnt_inc = (eff_cnt == COUNT_MAX) ? eff_cnt : eff_cnt + 32'd1;

  // signed difference ratio - value and its magnitude
  assign diff_full = {1'b0, ratio} - {1'b0, eff_val};
  assign diff_mag  = diff_full[17] ? 17'(-diff_full) : diff_full[16:0];

  assign explore_c  = rfrac_q < eps_value;
  // zero total gives 0, successes at or above total give 1.0
  assign ratio_skip = (tot_q == 16'd0) || (succ_q >= tot_q);

  // -------------------------------------------------------------------------
  // control
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    s_axis_tready    = 1'b0;
    mem_rd           = 1'b0;
    mem_we           = 1'b0;
    mem_addr         = cur_arm;
    div_req          = '0;
    mul_req          = '0;

    unique case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = s_axis_tuser[0] ? S_DONE : S_RD;
        end
      end
      S_RD: begin
        mem_rd     = 1'b1;
        state_next = S_RSTART;
      end
      S_RSTART: begin
        if (ratio_skip) begin
          state_next = S_VSTART;
        end else begin
          // remainder starts at succ, quotient is succ * 2^16 / tot
          div_req.start    = 1'b1;
          div_req.steps    = RATIO_STEPS;
          div_req.init_rem = {16'd0, succ_q};
          div_req.dividend = '0;
          div_req.divisor  = {16'd0, tot_q};
          state_next       = S_RDIV;
        end
      end
      S_RDIV: begin
        if (div_stat.done) begin
          state_next = S_VSTART;
        end
      end
      S_VSTART: begin
        div_req.start    = 1'b1;
        div_req.steps    = FULL_STEPS;
        div_req.init_rem = '0;
        div_req.dividend = diff_mag;
        div_req.divisor  = cnt_inc;
        state_next       = S_VDIV;
      end
      S_VDIV: begin
        if (div_stat.done) begin
          state_next = S_WR;
        end
      end
      S_WR: begin
        mem_we = 1'b1;
        if (explore_c) begin
          // random_arm mod NUM_ARMS beside the epsilon decay
          div_req.start    = 1'b1;
          div_req.steps    = FULL_STEPS;
          div_req.init_rem = '0;
          div_req.dividend = {1'b0, rarm_q};
          div_req.divisor  = 32'(NUM_ARMS);
          mul_req.start    = 1'b1;
          mul_req.a        = eps_value;
          mul_req.b        = decay;
          state_next       = S_EXPL;
        end else begin
          state_next = S_WALK;
        end
      end
      S_EXPL: begin
        if (div_stat.done) begin
          state_next = S_DONE;
        end
      end
      S_WALK: begin
        mem_rd   = 1'b1;
        mem_addr = walk_idx[AW-1:0];
        if (walk_idx == CW'(NUM_ARMS - 1)) begin
          state_next = S_WEND;
        end
      end
      S_WEND: begin
        state_next = S_PICK;
      end
      S_PICK: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // arm memory, registered read
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      val_mem[cur_arm] <= new_val;
      cnt_mem[cur_arm] <= cnt_new;
    end
    if (mem_rd) begin
      rd_val   <= val_mem[mem_addr];
      rd_cnt   <= cnt_mem[mem_addr];
      rd_valid <= arm_valid[mem_addr];
      rd_tag   <= mem_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arm_valid <= '0;
      rd_live   <= 1'b0;
    end else begin
      rd_live <= (state == S_WALK);
      if (state == S_IDLE && s_acc && s_axis_tuser[0]) begin
        arm_valid <= '0;
      end else if (mem_we) begin
        arm_valid[cur_arm] <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // control state: epsilon, current arm, output register
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      eps_value     <= EPS_INIT_RST;
      cur_arm       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we && paddr[3:2] == REG_EPS_INIT) begin
        eps_value <= pwdata[15:0];
      end else if (state == S_IDLE && s_acc && s_axis_tuser[0]) begin
        eps_value <= eps_restart;
      end else if (state == S_EXPL && div_stat.done) begin
        eps_value <= mul_prod;
      end

      if (state == S_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
        cur_arm       <= next_arm;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // datapath registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (s_acc) begin
          succ_q  <= s_axis_tdata[15:0];
          tot_q   <= s_axis_tdata[31:16];
          rfrac_q <= s_axis_tdata[47:32];
          rarm_q  <= s_axis_tdata[63:48];
          // reset item result
          ratio    <= 17'd0;
          new_val  <= 17'd0;
          explore  <= 1'b0;
          next_arm <= cur_arm;
        end
      end
      S_RSTART: begin
        if (tot_q == 16'd0) begin
          ratio <= 17'd0;
        end else if (succ_q >= tot_q) begin
          ratio <= Q16_ONE;
        end
      end
      S_RDIV: begin
        if (div_stat.done) begin
          ratio <= {1'b0, div_quo[15:0]};
        end
      end
      S_VSTART: begin
        cnt_new  <= cnt_inc;
        diff_neg <= diff_full[17];
      end
      S_VDIV: begin
        // truncated step toward the ratio, stays within 0..1.0
        if (div_stat.done) begin
          new_val <= diff_neg ? eff_val - div_quo : eff_val + div_quo;
        end
      end
      S_WR: begin
        explore  <= explore_c;
        walk_idx <= '0;
      end
      S_EXPL: begin
        if (div_stat.done) begin
          next_arm <= div_rem[AW-1:0];
        end
      end
      S_WALK: begin
        walk_idx <= walk_idx + CW'(1);
      end
      S_PICK: begin
        next_arm <= best_idx;
      end
      S_DONE: begin
        if (out_free) begin
          m_axis_tdata <= {eps_value, new_val, ratio, ARM_W'(next_arm)};
          m_axis_tuser <= explore;
        end
      end
      default: ;
    endcase

    // greedy compare, lowest index wins a tie
    if (rd_live) begin
      if (rd_tag == '0 || eff_val > best_val) begin
        best_val <= eff_val;
        best_idx <= rd_tag;
      end
    end
  end

  `EGAS_ASSERT(a_arm_in_range, clk, rst,
    m_axis_tvalid |-> ({1'b0, m_axis_tdata[5:0]} < 7'(NUM_ARMS)))
  `EGAS_ASSERT(a_value_in_range, clk, rst,
    m_axis_tvalid |-> (m_axis_tdata[39:23] <= Q16_ONE))
  `EGAS_ASSERT(a_decay_first, clk, rst,
    (state == S_EXPL && div_stat.done) |-> !mul_busy)
  `EGAS_ASSERT(a_accept_leaves_idle, clk, rst, s_acc |=> (state != S_IDLE))

endmodule

`default_nettype wire
